// File: hdl/wals_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the antialiased line stepper.
// No dependencies; imported by the divider and the top level.
package wals_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int FRAME_BITS = 15;
	localparam int COV_BITS   = 9;

	// widened coordinate: holds a coordinate plus one without wrapping
	localparam int EXT_W   = COORD_BITS + 2;
	localparam int SLOPE_W = FRAC_BITS + 2;
	localparam int ACC_W   = COORD_BITS + FRAC_BITS + 2;

	// serial divider: quotient magnitude goes up to exactly 1.0
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int REM_W  = COORD_BITS + 1;
	localparam int DCNT_W = $clog2(QUO_W + 1);

	localparam logic [FRAME_BITS-1:0] WIDTH_RESET  = FRAME_BITS'(640);
	localparam logic [FRAME_BITS-1:0] HEIGHT_RESET = FRAME_BITS'(480);

	// register indexes on the configuration port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// item modes
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [COORD_BITS-1:0] dividend;
		logic [COORD_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic [COV_BITS-1:0]          a_cov;
		logic                         a_ok;
		logic signed [COORD_BITS-1:0] b_x;
		logic signed [COORD_BITS-1:0] b_y;
		logic [COV_BITS-1:0]          b_cov;
		logic                         b_ok;
		logic                         last;
	} res_t;

endpackage

// File: hdl/wu_antialiased_line_stepper.sv
`timescale 1ns / 1ps
// Antialiased line stepper, one column item per input item.
// Advance: result registered on the accepting edge; the next item can follow while the output is free.
// Start: setup state PREP (first column registered once the output is free, then held while
// the output stalls), then the divider in DIV (skipped for a single point) and an accumulate
// state FIN; the next item is accepted once back in IDLE and the output is not stalled.
// Reset (arst_n low, asynchronous): idle, no line, no result pending, frame 640 x 480.
module wu_antialiased_line_stepper import wals_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] a_x,
	output logic signed [COORD_BITS-1:0] a_y,
	output logic [COV_BITS-1:0]          a_cov,
	output logic                         a_ok,
	output logic signed [COORD_BITS-1:0] b_x,
	output logic signed [COORD_BITS-1:0] b_y,
	output logic [COV_BITS-1:0]          b_cov,
	output logic                         b_ok,
	output logic                         last,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	state_t state_q, state_d;

	logic [FRAME_BITS-1:0] width_q, height_q;

	logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	logic                         active_q;
	logic                         steep_q;
	logic                         neg_q;
	logic signed [COORD_BITS-1:0] cur_q, fcol_q, frow_q, row0_q;
	logic signed [SLOPE_W-1:0]    slope_q;
	logic signed [ACC_W-1:0]      acc_q;

	logic out_valid_q;
	res_t res_q;

	logic     accept, out_free, prep_go, adv_go, load;
	res_t     res_d;
	div_req_t dreq;
	logic [QUO_W-1:0] dquo;
	logic             ddone;

	// setup signals
	logic signed [COORD_BITS:0]   ddx, ddy, major_d, minor_d;
	logic [COORD_BITS-1:0]        adx, ady, dxm, mag;
	logic                         steep, swap;
	logic signed [COORD_BITS-1:0] p0c, p0r, p1c, p1r, c0, r0, c1, r1;

	// advance signals
	logic signed [COORD_BITS:0] col_next;
	logic                       interior;
	logic signed [EXT_W-1:0]    row_fl, row_tr;
	logic [7:0]                 frac8;

	function automatic logic in_frame(input logic signed [EXT_W-1:0] x,
		input logic signed [EXT_W-1:0] y, input logic [FRAME_BITS-1:0] fw,
		input logic [FRAME_BITS-1:0] fh);
		in_frame = !x[EXT_W-1] && ($unsigned(x) < EXT_W'(fw)) &&
			!y[EXT_W-1] && ($unsigned(y) < EXT_W'(fh));
	endfunction

	// build one column: lower pixel and the one a row above on the minor axis
	function automatic res_t make_col(input logic signed [EXT_W-1:0] col,
		input logic signed [EXT_W-1:0] row, input logic [7:0] f8, input logic is_last,
		input logic stp, input logic [FRAME_BITS-1:0] fw, input logic [FRAME_BITS-1:0] fh);
		logic signed [EXT_W-1:0] ax, ay, bx, by, row1;
		logic [COV_BITS-1:0]     acov;
		res_t r;
		row1 = row + EXT_W'(1);
		if (stp) begin
			ax = row;  ay = col;
			bx = row1; by = col;
		end else begin
			ax = col;  ay = row;
			bx = col;  by = row1;
		end
		acov    = COV_BITS'(256) - {1'b0, f8};
		r.a_x   = ax[COORD_BITS-1:0];
		r.a_y   = ay[COORD_BITS-1:0];
		r.a_cov = acov;
		r.a_ok  = in_frame(ax, ay, fw, fh) && (acov != '0);
		r.b_x   = bx[COORD_BITS-1:0];
		r.b_y   = by[COORD_BITS-1:0];
		r.b_cov = {1'b0, f8};
		r.b_ok  = in_frame(bx, by, fw, fh) && (f8 != '0);
		r.last  = is_last;
		make_col = r;
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[FRAME_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign adv_go   = accept && (mode == MODE_ADVANCE) && active_q;
	assign prep_go  = (state_q == S_PREP) && out_free;
	assign load     = adv_go || prep_go;

	// setup: fold steepness and ordering into sign tests on the differences
	always_comb begin
		ddx     = {ex_q[COORD_BITS-1], ex_q} - {sx_q[COORD_BITS-1], sx_q};
		ddy     = {ey_q[COORD_BITS-1], ey_q} - {sy_q[COORD_BITS-1], sy_q};
		adx     = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : ddx[COORD_BITS-1:0];
		ady     = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : ddy[COORD_BITS-1:0];
		steep   = ady > adx;
		major_d = steep ? ddy : ddx;
		minor_d = steep ? ddx : ddy;
		swap    = major_d[COORD_BITS];
		dxm     = steep ? ady : adx;
		mag     = steep ? adx : ady;
		p0c     = steep ? sy_q : sx_q;
		p0r     = steep ? sx_q : sy_q;
		p1c     = steep ? ey_q : ex_q;
		p1r     = steep ? ex_q : ey_q;
		c0      = swap ? p1c : p0c;
		r0      = swap ? p1r : p0r;
		c1      = swap ? p0c : p1c;
		r1      = swap ? p0r : p1r;
	end

	// advance: next column, row truncated toward zero, top fraction bits
	always_comb begin
		col_next = {cur_q[COORD_BITS-1], cur_q} + (COORD_BITS+1)'(1);
		interior = col_next < $signed({fcol_q[COORD_BITS-1], fcol_q});
		row_fl   = acc_q[ACC_W-1:FRAC_BITS];
		row_tr   = (acc_q[ACC_W-1] && (acc_q[FRAC_BITS-1:0] != '0)) ?
			row_fl + EXT_W'(1) : row_fl;
		frac8    = acc_q[FRAC_BITS-1:FRAC_BITS-8];
	end

	// result selection
	always_comb begin
		if (state_q == S_PREP) begin
			res_d = make_col(EXT_W'(c0), EXT_W'(r0), 8'd0, 1'b0, steep, width_q, height_q);
		end else if (interior) begin
			res_d = make_col(EXT_W'(col_next), row_tr, frac8, 1'b0, steep_q,
				width_q, height_q);
		end else begin
			res_d = make_col(EXT_W'(fcol_q), EXT_W'(frow_q), 8'd0, 1'b1, steep_q,
				width_q, height_q);
		end
	end

	// divider
	assign dreq.start    = prep_go && (dxm != '0);
	assign dreq.dividend = mag;
	assign dreq.divisor  = dxm;

	wals_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.quo    (dquo),
		.done   (ddone)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept && mode == MODE_START) state_d = S_PREP;
			S_PREP: if (out_free) state_d = (dxm == '0) ? S_FIN : S_DIV;
			S_DIV:  if (ddone) state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		case (state_q)
			S_IDLE:  in_stall = out_valid_q && out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (prep_go) begin
				active_q <= 1'b1;
			end else if (adv_go && !interior) begin
				active_q <= 1'b0;
			end
		end
	end

	// payload: latch endpoints, line state and result item
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_START) begin
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
		end
		if (load) begin
			res_q <= res_d;
		end
		if (prep_go) begin
			steep_q <= steep;
			cur_q   <= c0;
			fcol_q  <= c1;
			frow_q  <= r1;
			row0_q  <= r0;
			neg_q   <= minor_d[COORD_BITS] ^ swap;
			slope_q <= SLOPE_W'(1) <<< FRAC_BITS;
		end
		if (state_q == S_DIV && ddone) begin
			slope_q <= neg_q ? -SLOPE_W'(dquo) : SLOPE_W'(dquo);
		end
		if (state_q == S_FIN) begin
			acc_q <= (ACC_W'(row0_q) <<< FRAC_BITS) + ACC_W'(slope_q);
		end else if (adv_go && interior) begin
			cur_q <= col_next[COORD_BITS-1:0];
			acc_q <= acc_q + ACC_W'(slope_q);
		end
	end

	assign out_valid = out_valid_q;
	assign a_x       = res_q.a_x;
	assign a_y       = res_q.a_y;
	assign a_cov     = res_q.a_cov;
	assign a_ok      = res_q.a_ok;
	assign b_x       = res_q.b_x;
	assign b_y       = res_q.b_y;
	assign b_cov     = res_q.b_cov;
	assign b_ok      = res_q.b_ok;
	assign last      = res_q.last;

endmodule

// File: hdl/wals_div.sv
`timescale 1ns / 1ps
// Restoring serial divider for the slope: (dividend << FRAC_BITS) / divisor.
// Depends on wals_pkg; the dividend must not exceed the divisor.
module wals_div import wals_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic [QUO_W-1:0] quo,
	output logic             done
);

	logic [REM_W-1:0]      rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic [DCNT_W-1:0]     cnt_q;
	logic [COORD_BITS-1:0] dsr_q;
	logic                  busy_q;

	logic [REM_W-1:0] trial;
	logic             qbit;
	logic [REM_W-1:0] kept;

	// one trial subtract a cycle
	always_comb begin
		trial = rem_q - {1'b0, dsr_q};
		qbit  = (rem_q >= {1'b0, dsr_q});
		kept  = qbit ? trial : rem_q;
	end

	// control: count the quotient bits down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: shift the partial remainder and collect quotient bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend};
			dsr_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {kept[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign done = busy_q && (cnt_q == DCNT_W'(1));
	assign quo  = {quo_q[QUO_W-2:0], qbit};

endmodule
